FILE: sv/servo_pose_interpolator_assert.svh
// assertion macros for the servo pose interpolator
// included by files that check their own logic; no other dependencies
`ifndef SERVO_POSE_INTERPOLATOR_ASSERT_SVH
`define SERVO_POSE_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SPI_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
`define SPI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define SPI_ASSERT(lbl, ck, rn, prop, msg)
`define SPI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`endif
`endif

FILE: sv/spi_pkg.sv
// shared constants, codes and controller/datapath structs
// no dependencies
package spi_pkg;

  localparam int SERVO_COUNT = 18;
  localparam int POS_BITS    = 12;
  localparam int STEP_W      = POS_BITS + 1;
  localparam int IDX_W       = $clog2(SERVO_COUNT);
  localparam int FUNC_W      = 2;
  localparam int ID_W        = 5;
  localparam int MS_W        = 16;
  localparam int PER_W       = 20;
  localparam int FMS_W       = 10;
  localparam int FRAMES_W    = 8;
  localparam int FRAMES_MAX  = 255;
  localparam int CTRL0_COUNT = 9;
  localparam int CH_MIRROR   = 24;
  localparam int CH_W        = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = PER_W;
  localparam int DIV_CNT_W   = $clog2(MS_W + 1);

  localparam logic [PER_W-1:0] PER_RESET = PER_W'(20000);
  localparam logic [FMS_W-1:0] FMS_RESET = FMS_W'(20);

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TARGET = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MS     = 1'd1;

  typedef enum logic {
    DIV_FRAMES,
    DIV_DIST
  } div_src_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_src_t div_src;
    logic     frames_wr;
    logic     step_wr;
    logic     upd;
    logic     upd_done;
    logic     idx_clr;
    logic     idx_inc;
    logic     start_done;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;
    logic fire;
    logic div_done;
    logic idx_last;
  } dp_sts_t;

endpackage

FILE: sv/spi_if.sv
// valid/ready channel interfaces for input and result words
// depends on spi_pkg
interface spi_in_if import spi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ID_W-1:0]     servo_id;
  logic [POS_BITS-1:0] position;
  logic [MS_W-1:0]     move_ms;

  modport source (output valid, func, servo_id, position, move_ms, input ready);
  modport sink (input valid, func, servo_id, position, move_ms, output ready);
endinterface

interface spi_out_if import spi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                controller;
  logic [CH_W-1:0]     channel;
  logic [POS_BITS-1:0] pulse_off;
  logic                moving;
  logic                last;

  modport source (output valid, controller, channel, pulse_off, moving, last, input ready);
  modport sink (input valid, controller, channel, pulse_off, moving, last, output ready);
endinterface

FILE: sv/servo_pose_interpolator.sv
// Eighteen-servo linear pose interpolator. Tick, set-target and load words are taken
// directly in the idle state. A start word sends the frame count and then each servo's step
// size through one shared restoring divider at one quotient bit per cycle (16 bits per
// division). A tick that ends a frame is accepted, then steps the servos one per cycle,
// then emits 18 result words, one per cycle while the sink is ready. No input word is taken
// until all 18 words of a frame are delivered.
// Depends on spi_pkg, spi_if, spi_ctrl, spi_dp and the assertion header.
`include "servo_pose_interpolator_assert.svh"
module servo_pose_interpolator import spi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  spi_in_if.sink                in_ch,
  spi_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  spi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  spi_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_ch.func),
    .in_servo_id    (in_ch.servo_id),
    .in_position    (in_ch.position),
    .in_move_ms     (in_ch.move_ms),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_controller (out_ch.controller),
    .out_channel    (out_ch.channel),
    .out_pulse_off  (out_ch.pulse_off),
    .out_moving     (out_ch.moving),
    .out_last       (out_ch.last)
  );

  `SPI_ASSERT(a_no_overlap, clk, rst_n, !(in_ch.ready && out_ch.valid), "ready while emitting")
  `SPI_ASSERT_IMP(a_last_ends, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.last, ##1 !out_ch.valid, "frame did not end after last word")
  `SPI_ASSERT_IMP(a_div_idle, clk, rst_n, !sts.div_done, !in_ch.ready, "divider busy while idle")

endmodule

FILE: sv/spi_ctrl.sv
// sequencer for start, frame update and result output
// depends on spi_pkg; drives the datapath through dp_cmd_t
module spi_ctrl import spi_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    in_ready,
  output logic    out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FR_GO,
    S_FR_WAIT,
    S_ST_GO,
    S_ST_WAIT,
    S_UPD,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.idx_clr = 1'b1;
        if (in_valid && in_ready_r) begin
          cmd.accept = 1'b1;
          if (sts.is_start) begin
            state_nxt = S_FR_GO;
          end else if (sts.fire) begin
            state_nxt = S_UPD;
          end
        end
      end
      S_FR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_FRAMES;
        state_nxt     = S_FR_WAIT;
      end
      S_FR_WAIT: begin
        if (sts.div_done) begin
          cmd.frames_wr = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_nxt     = S_ST_GO;
        end
      end
      S_ST_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_DIST;
        state_nxt     = S_ST_WAIT;
      end
      S_ST_WAIT: begin
        if (sts.div_done) begin
          cmd.step_wr = 1'b1;
          if (sts.idx_last) begin
            cmd.start_done = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_ST_GO;
          end
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts.idx_last) begin
          cmd.upd_done = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ready && out_valid_r) begin
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= (state_nxt == S_EMIT);
    end
  end

endmodule

FILE: sv/spi_dp.sv
// pose store, frame timer, shared restoring divider and output fields
// depends on spi_pkg; controlled by spi_ctrl through dp_cmd_t
module spi_dp import spi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [ID_W-1:0]       in_servo_id,
  input  logic [POS_BITS-1:0]   in_position,
  input  logic [MS_W-1:0]       in_move_ms,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic                  out_controller,
  output logic [CH_W-1:0]       out_channel,
  output logic [POS_BITS-1:0]   out_pulse_off,
  output logic                  out_moving,
  output logic                  out_last
);

  logic [PER_W-1:0]    period_r;
  logic [FMS_W-1:0]    fms_r;
  logic [POS_BITS-1:0] cur_r  [SERVO_COUNT];
  logic [POS_BITS-1:0] tgt_r  [SERVO_COUNT];
  logic [STEP_W-1:0]   step_r [SERVO_COUNT];
  logic                moving_r;
  logic [PER_W-1:0]    elapsed_r;
  logic [IDX_W-1:0]    idx_r;
  logic                pending_r;
  logic [MS_W-1:0]     mv_r;
  logic [FRAMES_W-1:0] frames_r;

  logic                div_busy_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [MS_W-1:0]     dvd_r;
  logic [FMS_W-1:0]    rem_r;
  logic [FMS_W-1:0]    dvs_r;

  logic                id_ok;
  logic [IDX_W-1:0]    id_idx;
  logic [PER_W-1:0]    el_inc;
  logic [POS_BITS-1:0] c, t, gap, new_pos;
  logic [STEP_W-1:0]   s, sum, dif;
  logic                up, near, pnd;
  logic [FMS_W:0]      trial;
  logic                ge;
  logic [FMS_W-1:0]    rem_nxt;
  logic [FRAMES_W-1:0] frames_nxt;
  logic [IDX_W-1:0]    ch_full;

  always_comb begin
    id_ok  = (in_servo_id != '0) && (in_servo_id <= ID_W'(SERVO_COUNT));
    id_idx = IDX_W'(in_servo_id - ID_W'(1));
    el_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;

    c    = cur_r[idx_r];
    t    = tgt_r[idx_r];
    s    = step_r[idx_r];
    up   = t > c;
    gap  = up ? (t - c) : (c - t);
    near = {1'b0, gap} < s;
    sum  = {1'b0, c} + s;
    dif  = {1'b0, c} - s;
    if (c == t) begin
      new_pos = c;
    end else if (near) begin
      new_pos = t;
    end else if (up) begin
      new_pos = sum[POS_BITS-1:0];
    end else begin
      new_pos = dif[POS_BITS-1:0];
    end
    pnd = (c != t) && !near;

    trial   = {rem_r, dvd_r[MS_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? FMS_W'(trial - {1'b0, dvs_r}) : FMS_W'(trial);

    if ((fms_r == '0) || (dvd_r >= MS_W'(FRAMES_MAX))) begin
      frames_nxt = FRAMES_W'(FRAMES_MAX);
    end else begin
      frames_nxt = FRAMES_W'(dvd_r + 1'b1);
    end

    sts.is_start = (in_func == FUNC_START);
    sts.fire     = (in_func == FUNC_TICK) && moving_r && (el_inc >= period_r);
    sts.div_done = !div_busy_r;
    sts.idx_last = (idx_r == IDX_W'(SERVO_COUNT - 1));

    ch_full        = (idx_r < IDX_W'(CTRL0_COUNT)) ? idx_r : IDX_W'(CH_MIRROR) - idx_r;
    out_controller = (idx_r >= IDX_W'(CTRL0_COUNT));
    out_channel    = ch_full[CH_W-1:0];
    out_pulse_off  = cur_r[idx_r];
    out_moving     = moving_r;
    out_last       = sts.idx_last;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PER_RESET;
      fms_r    <= FMS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_PERIOD: period_r <= cfg_data;
        CFG_FRAME_MS:     fms_r    <= cfg_data[FMS_W-1:0];
        default: ;
      endcase
    end
  end

  // pose store and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        cur_r[i]  <= '0;
        tgt_r[i]  <= '0;
        step_r[i] <= '0;
      end
      moving_r  <= 1'b0;
      elapsed_r <= '0;
      idx_r     <= '0;
      pending_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (in_func)
          FUNC_TICK: begin
            if (moving_r) begin
              elapsed_r <= (el_inc >= period_r) ? '0 : el_inc;
            end
          end
          FUNC_TARGET: begin
            if (id_ok) begin
              tgt_r[id_idx] <= in_position;
            end
          end
          FUNC_LOAD: begin
            if (id_ok) begin
              cur_r[id_idx] <= in_position;
              tgt_r[id_idx] <= in_position;
            end
          end
          default: ;
        endcase
      end
      if (cmd.step_wr) begin
        step_r[idx_r] <= STEP_W'(dvd_r) + 1'b1;
      end
      if (cmd.start_done) begin
        moving_r  <= 1'b1;
        elapsed_r <= '0;
      end
      if (cmd.upd) begin
        cur_r[idx_r] <= new_pos;
      end
      if (cmd.upd_done) begin
        moving_r <= pending_r | pnd;
      end
      if (cmd.idx_clr) begin
        idx_r     <= '0;
        pending_r <= 1'b0;
      end else begin
        if (cmd.idx_inc) begin
          idx_r <= idx_r + 1'b1;
        end
        if (cmd.upd) begin
          pending_r <= pending_r | pnd;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.is_start) begin
      mv_r <= in_move_ms;
    end
    if (cmd.frames_wr) begin
      frames_r <= frames_nxt;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= DIV_CNT_W'(MS_W);
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r - 1'b1;
      if (div_cnt_r == DIV_CNT_W'(1)) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      if (cmd.div_src == DIV_FRAMES) begin
        dvd_r <= mv_r;
        dvs_r <= fms_r;
      end else begin
        dvd_r <= MS_W'(gap);
        dvs_r <= FMS_W'(frames_r);
      end
    end else if (div_busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[MS_W-2:0], ge};
    end
  end

endmodule
